>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Constants, codes and control types shared by the set table modules.
// ----------------------------------------------------------------------------
package bst_pkg;

	// Table size and stored value width.
	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	// Port field widths.
	localparam int CMD_W     = 3;
	localparam int PORT_VAL_W = 32;
	localparam int POS_W     = 4;
	localparam int COUNT_W   = 5;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LIST     = 3'd4;

	typedef logic [VALUE_WIDTH-1:0] val_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic rank;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic list_run;
		logic k_last;
	} dp_stat_t;

endpackage

>>> sv/bst_ctrl.sv
// ----------------------------------------------------------------------------
// bst_ctrl
// Sequencer for the set table: accept, execute, rank pass and list pass.
// ----------------------------------------------------------------------------
module bst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bst_pkg::dp_stat_t stat,
	output bst_pkg::dp_cmd_t  cmd,
	output logic              busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_RANK = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.list_run ? ST_RANK : ST_IDLE;
			end
			ST_RANK: begin
				cmd.rank = 1'b1;
				if (stat.k_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.k_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> sv/bst_dp.sv
// ----------------------------------------------------------------------------
// bst_dp
// Set table datapath: entry registers, parallel lookup, remove shift,
// rank computation for ordered listing and the result registers.
// ----------------------------------------------------------------------------
module bst_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bst_pkg::dp_cmd_t                cmd,
	input  logic [bst_pkg::CMD_W-1:0]       command,
	input  logic [bst_pkg::PORT_VAL_W-1:0]  value,
	output bst_pkg::dp_stat_t               stat,
	output logic                            strobe,
	output logic                            found,
	output logic [bst_pkg::POS_W-1:0]       position,
	output logic [bst_pkg::COUNT_W-1:0]     count,
	output logic                            full_refused,
	output logic [bst_pkg::PORT_VAL_W-1:0]  element,
	output logic                            last
);

	localparam int CAP = bst_pkg::CAPACITY;

	// Latched word and table state.
	logic [bst_pkg::CMD_W-1:0] cmd_q;
	bst_pkg::val_t             val_q;
	bst_pkg::val_t             entry_q [CAP];
	bst_pkg::idx_t             rank_q  [CAP];
	bst_pkg::cnt_t             count_q;
	bst_pkg::idx_t             k_q;

	// Lookup and ordering signals.
	logic [CAP-1:0]  match;
	logic [CAP-1:0]  less;
	logic [CAP-1:0]  pick;
	logic            hit;
	bst_pkg::idx_t   hit_pos;
	logic            full;
	logic            k_last;
	bst_pkg::val_t   rank_sel;
	bst_pkg::idx_t   rank_val;
	bst_pkg::val_t   emit_sel;

	// Next result values.
	logic                   o_strobe;
	logic                   o_found;
	bst_pkg::idx_t          o_pos;
	bst_pkg::cnt_t          o_count;
	logic                   o_refused;
	bst_pkg::val_t          o_elem;
	logic                   o_last;

	// Parallel compare of the word against every live entry; entries are distinct.
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < CAP; i++) begin
			match[i] = (bst_pkg::CNT_W'(i) < count_q) && (entry_q[i] == val_q);
			if (match[i]) begin
				hit_pos = hit_pos | bst_pkg::IDX_W'(i);
			end
		end
		hit = |match;
	end

	assign full   = (count_q == bst_pkg::CNT_W'(CAP));
	assign k_last = ((bst_pkg::CNT_W'(k_q) + bst_pkg::CNT_W'(1)) == count_q);

	assign stat.list_run = (cmd_q == bst_pkg::CMD_LIST) && (count_q != '0);
	assign stat.k_last   = k_last;

	// Rank of entry k: how many live entries are smaller than it.
	assign rank_sel = entry_q[k_q];
	always_comb begin
		for (int j = 0; j < CAP; j++) begin
			less[j] = (bst_pkg::CNT_W'(j) < count_q) && (entry_q[j] < rank_sel);
		end
		rank_val = bst_pkg::IDX_W'($countones(less));
	end

	// Entry whose rank equals k is the k-th smallest.
	always_comb begin
		emit_sel = '0;
		for (int i = 0; i < CAP; i++) begin
			pick[i] = (bst_pkg::CNT_W'(i) < count_q) && (rank_q[i] == k_q);
			if (pick[i]) begin
				emit_sel = emit_sel | entry_q[i];
			end
		end
	end

	// Input word capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			val_q <= bst_pkg::VALUE_WIDTH'(value);
		end
	end

	// Entry storage: append on insert, close the gap on remove.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (cmd_q == bst_pkg::CMD_INSERT && !hit && !full) begin
				entry_q[count_q[bst_pkg::IDX_W-1:0]] <= val_q;
			end else if (cmd_q == bst_pkg::CMD_REMOVE && hit) begin
				for (int i = 0; i < CAP - 1; i++) begin
					if (bst_pkg::IDX_W'(i) >= hit_pos) begin
						entry_q[i] <= entry_q[i + 1];
					end
				end
			end
		end
	end

	// Rank storage, one entry per cycle of the rank pass.
	always_ff @(posedge clk) begin
		if (cmd.rank) begin
			rank_q[k_q] <= rank_val;
		end
	end

	// Element count and pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.exec) begin
				k_q <= '0;
				unique case (cmd_q)
					bst_pkg::CMD_INSERT: begin
						if (!hit && !full) begin
							count_q <= count_q + bst_pkg::CNT_W'(1);
						end
					end
					bst_pkg::CMD_REMOVE: begin
						if (hit) begin
							count_q <= count_q - bst_pkg::CNT_W'(1);
						end
					end
					bst_pkg::CMD_CLEAR: begin
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (cmd.rank || cmd.emit) begin
				k_q <= k_last ? '0 : k_q + bst_pkg::IDX_W'(1);
			end
		end
	end

	// Result word for the current cycle.
	always_comb begin
		o_strobe  = 1'b0;
		o_found   = 1'b0;
		o_pos     = '0;
		o_count   = count_q;
		o_refused = 1'b0;
		o_elem    = '0;
		o_last    = 1'b1;
		if (cmd.exec) begin
			unique case (cmd_q)
				bst_pkg::CMD_INSERT: begin
					o_strobe = 1'b1;
					if (hit) begin
						o_found = 1'b1;
						o_pos   = hit_pos;
					end else if (full) begin
						o_refused = 1'b1;
					end else begin
						o_count = count_q + bst_pkg::CNT_W'(1);
					end
				end
				bst_pkg::CMD_REMOVE: begin
					o_strobe = 1'b1;
					if (hit) begin
						o_found = 1'b1;
						o_pos   = hit_pos;
						o_count = count_q - bst_pkg::CNT_W'(1);
					end
				end
				bst_pkg::CMD_CONTAINS: begin
					o_strobe = 1'b1;
					o_found  = hit;
					o_pos    = hit ? hit_pos : '0;
				end
				bst_pkg::CMD_CLEAR: begin
					o_strobe = 1'b1;
					o_count  = '0;
				end
				bst_pkg::CMD_LIST: begin
					// Only an empty set answers here; otherwise the passes follow.
					o_strobe = (count_q == '0);
				end
				default: begin
					o_strobe = 1'b1;
				end
			endcase
		end else if (cmd.emit) begin
			o_strobe = 1'b1;
			o_elem   = emit_sel;
			o_last   = k_last;
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= o_strobe;
		end
	end

	always_ff @(posedge clk) begin
		found        <= o_found;
		position     <= bst_pkg::POS_W'(o_pos);
		count        <= bst_pkg::COUNT_W'(o_count);
		full_refused <= o_refused;
		element      <= bst_pkg::PORT_VAL_W'(o_elem);
		last         <= o_last;
	end

endmodule

>>> sv/bounded_set_table.sv
// ----------------------------------------------------------------------------
// bounded_set_table
// Set of distinct values in a sixteen-entry table kept in insertion order.
//
// A word is taken at a rising edge where start is high and busy is low; it
// carries command (insert, remove, contains, clear, list) and value. Results
// leave on found, position, count, full_refused, element and last, each for
// exactly one cycle marked by strobe; the receiver cannot hold them off.
// Insert, remove, contains, clear and unused codes give one result: the word
// is latched, executed and its result registered. Busy is high while it
// executes, so a new word can be taken while that result is out. Lookup
// compares all entries in parallel. List runs a rank pass over the n live
// entries, one entry ranked per cycle, then emits n results in ascending
// order on consecutive cycles, the final one with last set. An empty list
// gives one result at once. Reset empties the set, not the entry registers.
// ----------------------------------------------------------------------------
module bounded_set_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [bst_pkg::CMD_W-1:0]      command,
	input  logic [bst_pkg::PORT_VAL_W-1:0] value,
	output logic                           strobe,
	output logic                           found,
	output logic [bst_pkg::POS_W-1:0]      position,
	output logic [bst_pkg::COUNT_W-1:0]    count,
	output logic                           full_refused,
	output logic [bst_pkg::PORT_VAL_W-1:0] element,
	output logic                           last
);

	bst_pkg::dp_cmd_t  dp_cmd;
	bst_pkg::dp_stat_t dp_stat;

	// Controller.
	bst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (dp_cmd),
		.busy   (busy)
	);

	// Datapath.
	bst_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.command      (command),
		.value        (value),
		.stat         (dp_stat),
		.strobe       (strobe),
		.found        (found),
		.position     (position),
		.count        (count),
		.full_refused (full_refused),
		.element      (element),
		.last         (last)
	);

endmodule

>>> sv/bst_checker.sv
// ----------------------------------------------------------------------------
// bst_checker
// Port-level checks of the set table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bst_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        strobe,
	input logic                        found,
	input logic                        full_refused,
	input logic                        last,
	input logic [bst_pkg::COUNT_W-1:0] count
);

	// An accepted word makes the block busy in the next cycle.
	`BST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

	// A list run is emitted on consecutive cycles until its last word.
	`BST_ASSERT_NEXT(a_run_cont, strobe && !last, strobe, "gap inside a list run")

	// While a list run is still going the block takes no new word.
	`BST_ASSERT_NOW(a_run_busy, strobe && !last, busy, "idle in the middle of a list run")

	// A refused insert only happens on a full table with the value absent.
	`BST_ASSERT_NOW(a_refused, strobe && full_refused, !found && (count == bst_pkg::COUNT_W'(bst_pkg::CAPACITY)), "refusal on a table that is not full")

	// The count never exceeds the capacity.
	`BST_ASSERT_NOW(a_count_max, strobe, count <= bst_pkg::COUNT_W'(bst_pkg::CAPACITY), "count beyond capacity")

endmodule

bind bounded_set_table bst_checker u_bst_checker (.*);

>>> tb/sv/bounded_set_table_test.sv
// ----------------------------------------------------------------------------
// bounded_set_table_test
// Self-checking bench for the bounded set table. Command words go in over the
// start/busy handshake, and an in-bench copy of the table predicts every
// result. A monitor compares each strobed result, field by field, with the
// oldest prediction. Directed cases come first: empty table, extreme values,
// a full table with a refused insert, removal and a spare code. Random
// traffic over a small value pool follows in phases with no sender idling,
// with heavy idling and with moderate idling.
// ----------------------------------------------------------------------------
module bounded_set_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Codes five to seven are spare and must be ignored by the block.
	localparam logic [bst_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [bst_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_GAP = 12;
	localparam int POOL_SIZE = 20;

	// One result as it appears on the output ports.
	typedef struct packed {
		logic                           found;
		logic [bst_pkg::POS_W-1:0]      position;
		logic [bst_pkg::COUNT_W-1:0]    count;
		logic                           full_refused;
		logic [bst_pkg::PORT_VAL_W-1:0] element;
		logic                           last;
	} table_reply_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [bst_pkg::CMD_W-1:0]      command;
	logic [bst_pkg::PORT_VAL_W-1:0] value;
	logic                           strobe;
	logic                           found;
	logic [bst_pkg::POS_W-1:0]      position;
	logic [bst_pkg::COUNT_W-1:0]    count;
	logic                           full_refused;
	logic [bst_pkg::PORT_VAL_W-1:0] element;
	logic                           last;

	// Shadow copy of the table, in insertion order.
	bst_pkg::val_t set_vals [bst_pkg::CAPACITY];
	int            set_size;

	table_reply_t reply_q [$];

	int idle_pct;
	int err_cnt;
	int words_sent;
	int replies_seen;
	int refused_cnt;
	int longest_list;
	int cyc;

	bounded_set_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.value        (value),
		.strobe       (strobe),
		.found        (found),
		.position     (position),
		.count        (count),
		.full_refused (full_refused),
		.element      (element),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cyc, reply_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Update the shadow table for one accepted word and queue its results.
	task automatic predict_reply(input logic [bst_pkg::CMD_W-1:0] cmd,
		input bst_pkg::val_t v);
		int            i;
		int            j;
		int            hit;
		bst_pkg::val_t x;
		bst_pkg::val_t ordered [bst_pkg::CAPACITY];
		table_reply_t  r;
		hit = -1;
		for (i = 0; i < set_size; i++)
			if (hit < 0 && set_vals[i] == v)
				hit = i;
		r = '0;
		r.last = 1'b1;
		case (cmd)
			bst_pkg::CMD_INSERT: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.position = bst_pkg::POS_W'(hit);
				end else if (set_size >= bst_pkg::CAPACITY) begin
					r.full_refused = 1'b1;
					refused_cnt++;
				end else begin
					set_vals[set_size] = v;
					set_size++;
				end
				r.count = bst_pkg::COUNT_W'(set_size);
				reply_q.push_back(r);
			end
			bst_pkg::CMD_REMOVE, bst_pkg::CMD_CONTAINS: begin
				if (hit >= 0) begin
					if (cmd == bst_pkg::CMD_REMOVE) begin
						for (i = hit; i + 1 < set_size; i++)
							set_vals[i] = set_vals[i + 1];
						set_size--;
					end
					r.found = 1'b1;
					r.position = bst_pkg::POS_W'(hit);
				end
				r.count = bst_pkg::COUNT_W'(set_size);
				reply_q.push_back(r);
			end
			bst_pkg::CMD_CLEAR: begin
				set_size = 0;
				reply_q.push_back(r);
			end
			bst_pkg::CMD_LIST: begin
				if (set_size == 0) begin
					reply_q.push_back(r);
				end else begin
					// Insertion sort of a copy; entries are distinct.
					for (i = 0; i < set_size; i++) begin
						x = set_vals[i];
						j = i;
						while (j > 0 && ordered[j - 1] > x) begin
							ordered[j] = ordered[j - 1];
							j--;
						end
						ordered[j] = x;
					end
					for (i = 0; i < set_size; i++) begin
						r.count = bst_pkg::COUNT_W'(set_size);
						r.element = ordered[i];
						r.last = (i == set_size - 1);
						reply_q.push_back(r);
					end
					if (set_size > longest_list)
						longest_list = set_size;
				end
			end
			default: begin
				r.count = bst_pkg::COUNT_W'(set_size);
				reply_q.push_back(r);
			end
		endcase
	endtask

	// Offer one word after a random idle gap and hold it until it is taken.
	task automatic send_word(input logic [bst_pkg::CMD_W-1:0] cmd,
		input bst_pkg::val_t v);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			// Junk on the payload while start is low must be ignored.
			start   <= 1'b0;
			command <= bst_pkg::CMD_W'($urandom_range(7));
			value   <= $urandom;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		command <= cmd;
		value   <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_reply(cmd, v);
		words_sent++;
	endtask

	// A random value that is not in the table yet.
	function automatic bst_pkg::val_t fresh_value();
		bst_pkg::val_t v;
		bit            taken;
		int            i;
		do begin
			v = $urandom;
			taken = 1'b0;
			for (i = 0; i < set_size; i++)
				if (set_vals[i] == v)
					taken = 1'b1;
		end while (taken);
		return v;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// Compare every strobed result with the oldest prediction.
	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			replies_seen++;
			if (reply_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual count %0h element %0h",
					$time, count, element);
				err_cnt++;
			end else begin
				want = reply_q.pop_front();
				report_field("found", 32'(want.found), 32'(found));
				report_field("position", 32'(want.position), 32'(position));
				report_field("count", 32'(want.count), 32'(count));
				report_field("full_refused", 32'(want.full_refused), 32'(full_refused));
				report_field("element", 32'(want.element), 32'(element));
				report_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	// Lookups and listing on an empty table.
	task automatic test_empty_table();
		send_word(bst_pkg::CMD_LIST, '0);
		send_word(bst_pkg::CMD_REMOVE, 32'h1234_5678);
	endtask

	// Smallest and largest values, and a duplicate insert.
	task automatic test_value_extremes();
		send_word(bst_pkg::CMD_INSERT, '0);
		send_word(bst_pkg::CMD_INSERT, '1);
		send_word(bst_pkg::CMD_INSERT, '0);
	endtask

	// Fill the table, have one insert refused, then list all of it.
	task automatic test_full_table();
		while (set_size < bst_pkg::CAPACITY)
			send_word(bst_pkg::CMD_INSERT, fresh_value());
		send_word(bst_pkg::CMD_INSERT, fresh_value());
		send_word(bst_pkg::CMD_LIST, '0);
	endtask

	// Remove the head entry, miss on it, try a spare code, then clear.
	task automatic test_remove_and_spare();
		send_word(bst_pkg::CMD_REMOVE, '0);
		send_word(bst_pkg::CMD_CONTAINS, '0);
		send_word(CMD_SPARE_HI, $urandom);
		send_word(bst_pkg::CMD_CLEAR, $urandom);
	endtask

	// Random commands over a small value pool so that hits, full tables
	// and long ordered lists come up often.
	task automatic test_random_traffic(input int n_words, input int pct);
		bst_pkg::val_t             pool [POOL_SIZE];
		int                        k;
		int                        sel;
		logic [bst_pkg::CMD_W-1:0] cmd;
		bst_pkg::val_t             v;
		idle_pct = pct;
		pool[0] = '0;
		pool[1] = '1;
		for (k = 2; k < POOL_SIZE; k++)
			pool[k] = $urandom;
		for (k = 0; k < n_words; k++) begin
			sel = $urandom_range(99);
			if (sel < 45)
				cmd = bst_pkg::CMD_INSERT;
			else if (sel < 60)
				cmd = bst_pkg::CMD_REMOVE;
			else if (sel < 80)
				cmd = bst_pkg::CMD_CONTAINS;
			else if (sel < 93)
				cmd = bst_pkg::CMD_LIST;
			else if (sel < 95)
				cmd = bst_pkg::CMD_CLEAR;
			else
				cmd = bst_pkg::CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
			if ($urandom_range(99) < 85)
				v = pool[$urandom_range(POOL_SIZE - 1)];
			else
				v = $urandom;
			send_word(cmd, v);
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		command  <= bst_pkg::CMD_INSERT;
		value    <= '0;
		set_size = 0;
		idle_pct = 0;
		err_cnt = 0;
		words_sent = 0;
		replies_seen = 0;
		refused_cnt = 0;
		longest_list = 0;
		cyc = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_value_extremes();
		test_full_table();
		test_remove_and_spare();
		test_random_traffic(58, 0);
		test_random_traffic(58, 52);
		test_random_traffic(58, 29);

		// Let the last results drain, then watch for strays.
		start <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d command words and checked %0d results, with %0d refused inserts",
			words_sent, replies_seen, refused_cnt);
		$display("and ordered lists of up to %0d entries, under three sender idle rates.",
			longest_list);
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
